// ===== rtl/core/magnetometer_heading_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the magnetometer heading block
// Checks compile in simulation and collapse to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_HEADING_TOP_MACROS_SVH
`define MAGNETOMETER_HEADING_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, held off during reset
`define MHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, held off during reset
`define MHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mhd_pkg.sv =====
// ---------------------------------------------------------------------------
// mhd_pkg
// Types and constants shared by the magnetometer heading pipeline.
// ---------------------------------------------------------------------------
package mhd_pkg;

    // field and register widths
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 2'd2;

    localparam logic [CFG_W-1:0] SPAN_RESET = 16'd1;
    localparam logic [CFG_W-1:0] DECL_RESET = 16'd432;

    // product field*span: 16 bit signed by 17 bit signed (zero-extended span)
    localparam int PROD_W = 33;
    // CORDIC vector: products plus negation and CORDIC gain headroom
    localparam int VEC_W  = 36;
    // angle in 1/256 centidegree, covers -2.6e6 .. 7.2e6
    localparam int ANG_W  = 25;
    // heading sum before wrap, covers -42768 .. 60767
    localparam int SUM_W  = 18;

    localparam int MAX_STEPS = 24;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [ANG_W-1:0]  t_angle;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // angle constants
    localparam t_angle HALF_TURN_SCALED = 25'sd4608000;
    localparam t_angle ROUND_HALF       = 25'sd128;
    localparam int     ANGLE_FRAC       = 8;

    localparam t_sum FULL_TURN   = 18'sd36000;
    localparam t_sum DOUBLE_TURN = 18'sd72000;
    localparam t_sum ZERO_SUM    = 18'sd0;

    // atan(2^-i) in 1/256 centidegree, rounded
    localparam t_angle ATAN_TABLE [MAX_STEPS] = '{
        25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
        25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
        25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
        25'sd358,     25'sd179,    25'sd90,     25'sd45,
        25'sd22,      25'sd11,     25'sd6,      25'sd3,
        25'sd1,       25'sd1,      25'sd0,      25'sd0
    };

    // one item inside the rotation pipeline
    typedef struct packed {
        t_vec   x;
        t_vec   y;
        t_angle z;
        logic   zero;   // both products zero: angle forced to 0
        logic   err;    // a span is zero
    } t_cordic;

endpackage

// ===== rtl/core/mhd_in_if.sv =====
// ---------------------------------------------------------------------------
// mhd_in_if
// Sample channel: one X/Y magnetometer reading pair per item.
// ---------------------------------------------------------------------------
interface mhd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mhd_pkg::FIELD_W-1:0]  field_x;
    logic signed [mhd_pkg::FIELD_W-1:0]  field_y;

    modport source (output valid, output field_x, output field_y, input ready);
    modport sink   (input valid, input field_x, input field_y, output ready);
endinterface

// ===== rtl/core/mhd_out_if.sv =====
// ---------------------------------------------------------------------------
// mhd_out_if
// Result channel: heading in centidegrees plus calibration error flag.
// ---------------------------------------------------------------------------
interface mhd_out_if;
    logic                          valid;
    logic                          ready;
    logic [mhd_pkg::FIELD_W-1:0]   heading_centideg;
    logic                          calibration_error;

    modport source (output valid, output heading_centideg, output calibration_error,
                    input ready);
    modport sink   (input valid, input heading_centideg, input calibration_error,
                    output ready);
endinterface

// ===== rtl/core/mhd_cfg_if.sv =====
// ---------------------------------------------------------------------------
// mhd_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface mhd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mhd_pkg::CFG_IDX_W-1:0]   index;
    logic [mhd_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mhd_cordic_stage.sv =====
// ---------------------------------------------------------------------------
// mhd_cordic_stage
// One vectoring CORDIC iteration with its pipeline register.
// ---------------------------------------------------------------------------
module mhd_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  mhd_pkg::t_cordic i_stage,
    output mhd_pkg::t_cordic o_stage
);

    mhd_pkg::t_cordic r_stage;
    mhd_pkg::t_cordic n_stage;
    mhd_pkg::t_vec    dx;
    mhd_pkg::t_vec    dy;

    // floor shifts of the cross terms
    assign dx = i_stage.y >>> SHIFT;
    assign dy = i_stage.x >>> SHIFT;

    // rotate toward the x axis; y == 0 takes the negative branch
    always_comb begin
        n_stage = i_stage;
        if (i_stage.y > 0) begin
            n_stage.x = i_stage.x + dx;
            n_stage.y = i_stage.y - dy;
            n_stage.z = i_stage.z + mhd_pkg::ATAN_TABLE[SHIFT];
        end else begin
            n_stage.x = i_stage.x - dx;
            n_stage.y = i_stage.y + dy;
            n_stage.z = i_stage.z - mhd_pkg::ATAN_TABLE[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/core/magnetometer_heading_top.sv =====
// ---------------------------------------------------------------------------
// magnetometer_heading_top
// Compass heading from a magnetometer X/Y pair: span scaling by cross
// multiplication, pipelined atan2 CORDIC, declination add and wrap.
// ---------------------------------------------------------------------------
//
//  channel    dir  payload                               handshake
//  i_cfg      in   index[1:0], data[15:0]                valid/ready, ready always 1
//  i_sample   in   field_x[15:0], field_y[15:0] signed   valid/ready
//  o_res      out  heading_centideg[15:0], cal. error    valid/ready
//
//  The stages are multiply, prepare, one stage per CORDIC iteration (CORDIC_STEPS,
//  capped at MAX_STEPS), round and add, wrap into the output register.
//  One item per cycle is accepted unless a stall has filled the pipeline;
//  each stage holds a valid bit and loads when it is empty or its successor
//  loads, so bubbles close up under a stall. Synchronous active-low reset
//  clears valid bits and the config registers (span_x = 1, span_y = 1, declination = 432).
//
`include "magnetometer_heading_top_macros.svh"

module magnetometer_heading_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhd_cfg_if.sink     i_cfg,
    mhd_in_if.sink      i_sample,
    mhd_out_if.source   o_res
);

    localparam int NC  = (CORDIC_STEPS < mhd_pkg::MAX_STEPS) ?
                         CORDIC_STEPS : mhd_pkg::MAX_STEPS;
    // stage map: 0 multiply, 1 prepare, 2..NC+1 CORDIC, NC+2 sum, NC+3 output
    localparam int NST = NC + 4;
    localparam int S_PREP = 1;
    localparam int S_SUM  = NC + 2;
    localparam int S_OUT  = NC + 3;

    // configuration registers
    logic [mhd_pkg::CFG_W-1:0]        r_span_x;
    logic [mhd_pkg::CFG_W-1:0]        r_span_y;
    logic signed [mhd_pkg::CFG_W-1:0] r_decl;

    // pipeline control
    logic [NST-1:0] r_valid;
    logic [NST-1:0] adv;

    // stage payloads
    mhd_pkg::t_prod    r_px;
    mhd_pkg::t_prod    r_py;
    logic              r_err_m;
    mhd_pkg::t_cordic  r_prep;
    mhd_pkg::t_cordic  n_prep;
    mhd_pkg::t_cordic  w [0:NC];
    mhd_pkg::t_sum     r_sum;
    mhd_pkg::t_sum     n_sum;
    logic              r_err_s;
    logic [mhd_pkg::FIELD_W-1:0] r_heading;
    logic [mhd_pkg::FIELD_W-1:0] n_heading;
    logic              r_err_o;

    logic signed [mhd_pkg::CFG_W:0] span_x_ext;
    logic signed [mhd_pkg::CFG_W:0] span_y_ext;
    mhd_pkg::t_vec   px_ext;
    mhd_pkg::t_vec   py_ext;
    mhd_pkg::t_angle z_round;
    mhd_pkg::t_sum   z_cd;
    mhd_pkg::t_sum   decl_ext;

    // config writes, unknown indexes dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_x <= mhd_pkg::SPAN_RESET;
            r_span_y <= mhd_pkg::SPAN_RESET;
            r_decl   <= mhd_pkg::DECL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mhd_pkg::REG_SPAN_X:      r_span_x <= i_cfg.data;
                mhd_pkg::REG_SPAN_Y:      r_span_y <= i_cfg.data;
                mhd_pkg::REG_DECLINATION: r_decl   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // load enables: a stage loads when empty or when its successor loads
    always_comb begin
        adv[NST-1] = !r_valid[NST-1] || o_res.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign i_sample.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= i_sample.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // stage 0: cross products field_x*span_y, field_y*span_x
    assign span_x_ext = {1'b0, r_span_x};
    assign span_y_ext = {1'b0, r_span_y};

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_px    <= mhd_pkg::t_prod'(i_sample.field_x) * mhd_pkg::t_prod'(span_y_ext);
            r_py    <= mhd_pkg::t_prod'(i_sample.field_y) * mhd_pkg::t_prod'(span_x_ext);
            r_err_m <= (r_span_x == '0) || (r_span_y == '0);
        end
    end

    // stage 1: fold left half-plane onto the right, flag the zero vector
    assign px_ext = mhd_pkg::t_vec'(r_px);
    assign py_ext = mhd_pkg::t_vec'(r_py);

    always_comb begin
        n_prep.err  = r_err_m;
        n_prep.zero = (r_px == '0) && (r_py == '0);
        if (r_px < 0) begin
            n_prep.x = -px_ext;
            n_prep.y = -py_ext;
            n_prep.z = mhd_pkg::HALF_TURN_SCALED;
        end else begin
            n_prep.x = px_ext;
            n_prep.y = py_ext;
            n_prep.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[S_PREP]) begin
            r_prep <= n_prep;
        end
    end

    // CORDIC iterations, one register stage each
    assign w[0] = r_prep;

    for (genvar g = 0; g < NC; g++) begin : g_cordic
        mhd_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_load  (adv[g+2]),
            .i_stage (w[g]),
            .o_stage (w[g+1])
        );
    end

    // round angle to centidegrees and add declination
    assign z_round  = (w[NC].z + mhd_pkg::ROUND_HALF) >>> mhd_pkg::ANGLE_FRAC;
    assign z_cd     = w[NC].zero ? mhd_pkg::ZERO_SUM : z_round[mhd_pkg::SUM_W-1:0];
    assign decl_ext = mhd_pkg::t_sum'(r_decl);
    assign n_sum    = z_cd + decl_ext;

    always_ff @(posedge i_clk) begin
        if (adv[S_SUM]) begin
            r_sum   <= n_sum;
            r_err_s <= w[NC].err;
        end
    end

    // wrap into 0..35999; error items report heading 0
    always_comb begin
        mhd_pkg::t_sum h;
        if (r_sum < -mhd_pkg::FULL_TURN) begin
            h = r_sum + mhd_pkg::DOUBLE_TURN;
        end else if (r_sum < 0) begin
            h = r_sum + mhd_pkg::FULL_TURN;
        end else if (r_sum >= mhd_pkg::FULL_TURN) begin
            h = r_sum - mhd_pkg::FULL_TURN;
        end else begin
            h = r_sum;
        end
        n_heading = r_err_s ? '0 : h[mhd_pkg::FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[S_OUT]) begin
            r_heading <= n_heading;
            r_err_o   <= r_err_s;
        end
    end

    assign o_res.valid             = r_valid[S_OUT];
    assign o_res.heading_centideg  = r_heading;
    assign o_res.calibration_error = r_err_o;

    // checks
    `MHD_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, o_res.valid, o_res.heading_centideg < 16'd36000, "heading out of range")
    `MHD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_res.valid && o_res.calibration_error, o_res.heading_centideg == '0, "error item with nonzero heading")
    `MHD_ASSERT_NOW(a_prep_right_half, i_clk, i_rst_n, r_valid[S_PREP], !r_prep.x[mhd_pkg::VEC_W-1], "folded vector has negative x")
    `MHD_ASSERT_NEXT(a_item_moves, i_clk, i_rst_n, r_valid[0] && adv[S_PREP], r_valid[S_PREP], "item lost entering prepare stage")

endmodule
